// ----- rtl/core/ghpt_pkg.sv -----
// Shared types, constants and saturation helpers for the gyro heading PID turn block.
package ghpt_pkg;

   localparam int unsigned ACC_W   = 48;
   localparam int unsigned HEAD_W  = 24;
   localparam int unsigned GOAL_W  = 26;
   localparam int unsigned PROD_W  = 64;
   localparam int unsigned MULB_W  = 16;
   localparam int unsigned DIVD_W  = 10;

   localparam logic [3:0] MUL_LAST = 4'd15;
   localparam logic [5:0] DIV_LAST = 6'd47;

   localparam logic [DIVD_W-1:0] MILLI = 10'd1000;

   localparam logic signed [HEAD_W-1:0] H_MAX = {1'b0, {(HEAD_W-1){1'b1}}};
   localparam logic signed [HEAD_W-1:0] H_MIN = {1'b1, {(HEAD_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0]  A_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic signed [1:0] DIR_FWD  = 2'sb01;
   localparam logic signed [1:0] DIR_REV  = 2'sb11;
   localparam logic signed [1:0] DIR_STOP = 2'sb00;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic [2:0] {
      CSR_KP       = 3'd0,
      CSR_KI       = 3'd1,
      CSR_KD       = 3'd2,
      CSR_PERIOD   = 3'd3,
      CSR_DEADBAND = 3'd4,
      CSR_MINSPD   = 3'd5,
      CSR_LIMIT    = 3'd6,
      CSR_BAND     = 3'd7
   } csr_idx_type;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_ERR  = 12'b0000_0000_0010,
      S_MINT = 12'b0000_0000_0100,
      S_DDIV = 12'b0000_0000_1000,
      S_IDIV = 12'b0000_0001_0000,
      S_MKP  = 12'b0000_0010_0000,
      S_MKI  = 12'b0000_0100_0000,
      S_MKD  = 12'b0000_1000_0000,
      S_GYRO = 12'b0001_0000_0000,
      S_MGY  = 12'b0010_0000_0000,
      S_HDIV = 12'b0100_0000_0000,
      S_OUT  = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic go;
      logic done;
   } unit_ctl_type;

   // Clamp a 27-bit signed value into 24 bits.
   function automatic logic signed [HEAD_W-1:0] sat24(input logic signed [26:0] v);
      logic hi_same;
      hi_same = (v[26:23] == 4'b0000) || (v[26:23] == 4'b1111);
      if (hi_same) return v[23:0];
      return v[26] ? H_MIN : H_MAX;
   endfunction

   // Clamp a 49-bit signed value into 48 bits.
   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
      if (v[ACC_W] == v[ACC_W-1]) return v[ACC_W-1:0];
      return v[ACC_W] ? A_MIN : A_MAX;
   endfunction

endpackage

// ----- rtl/core/ghpt_ifs.sv -----
// Channel interfaces: request, response and register write.
interface ghpt_req_if import ghpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [12:0] turn_target;
   logic [9:0]         elapsed_ms;
   logic               gyro_valid;
   logic signed [15:0] gyro_rate;
   modport source (output valid, req_type, turn_target, elapsed_ms, gyro_valid, gyro_rate,
                   input ready);
   modport sink   (input valid, req_type, turn_target, elapsed_ms, gyro_valid, gyro_rate,
                   output ready);
endinterface

interface ghpt_rsp_if import ghpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [1:0]  dir_a;
   logic signed [1:0]  dir_b;
   logic [7:0]         drive_speed;
   logic               turn_active;
   logic               turn_done;
   logic signed [HEAD_W-1:0] heading;
   modport source (output valid, dir_a, dir_b, drive_speed, turn_active, turn_done, heading,
                   input ready);
   modport sink   (input valid, dir_a, dir_b, drive_speed, turn_active, turn_done, heading,
                   output ready);
endinterface

interface ghpt_csr_if import ghpt_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [15:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/ghpt_smul.sv -----
// Bit-serial shift-and-add multiplier: signed 48-bit by unsigned 16-bit.
module ghpt_smul import ghpt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  unit_ctl_type             ctl_i,
   input  logic signed [ACC_W-1:0]  op_a,
   input  logic [MULB_W-1:0]        op_b,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);
   logic signed [PROD_W-1:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [MULB_W-1:0]        mplier_ff, mplier_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (ctl_i.go) begin
         mcand_in  = {{(PROD_W-ACC_W){op_a[ACC_W-1]}}, op_a};
         mplier_in = op_b;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // one multiplier bit per cycle
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 4'd1;
         if (cnt_ff == MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ----- rtl/core/ghpt_sdiv.sv -----
// Bit-serial restoring divider: unsigned 48-bit by unsigned 10-bit.
module ghpt_sdiv import ghpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  unit_ctl_type      ctl_i,
   input  logic [ACC_W-1:0]  dividend,
   input  logic [DIVD_W-1:0] divisor,
   output logic              done,
   output logic [ACC_W-1:0]  quotient
);
   logic [ACC_W-1:0]  num_ff, num_in;
   logic [DIVD_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [DIVD_W:0]   trial;
   logic              fits;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   assign trial = {rem_ff, num_ff[ACC_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl_i.go) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, shift out one quotient bit
         if (fits) rem_in = DIVD_W'(trial - {1'b0, den_ff});
         else      rem_in = trial[DIVD_W-1:0];
         num_in = {num_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;
endmodule

// ----- rtl/core/gyro_heading_pid_turn.sv -----
// Top level: gyro heading integration and PID turn controller.
//
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+------------------------------------------------
//  req_ch   | in  | valid / ready   | req_type, turn_target, elapsed_ms, gyro_valid, rate
//  rsp_ch   | out | valid / ready   | dir_a, dir_b, drive_speed, turn_active, done, heading
//  csr_ch   | in  | valid / ready=1 | addr (register index), data
//
// One word is in work at a time. A start word goes straight to the output step. A tick
// with no turn running and no gyro integration passes only the gyro check, and a
// turning tick with a gyro update takes longest: the shared bit-serial multiplier (four
// products, five with a gyro update) and the bit-serial divider (up to three quotients)
// set its length.
// Reset is synchronous; it restores the register defaults and clears the heading,
// the turn and the integral. A waiting response does not block the next request:
// the block stalls only in its last step until the response register is free.
module gyro_heading_pid_turn import ghpt_pkg::*; (
   input logic        clock,
   input logic        reset,
   ghpt_req_if.sink   req_ch,
   ghpt_rsp_if.source rsp_ch,
   ghpt_csr_if.sink   csr_ch
);
   // configuration
   logic [15:0] kp_ff, ki_ff, kd_ff;
   logic [9:0]  period_ff;
   logic [11:0] deadband_ff, band_ff;
   logic [7:0]  minspd_ff, limit_ff;

   state_type state_ff, state_in;

   logic signed [ACC_W-1:0]  acc_ff, acc_in, integ_ff, integ_in;
   logic signed [HEAD_W-1:0] heading_ff, heading_in, prev_ff, prev_in, err_ff, err_in;
   logic signed [GOAL_W-1:0] goal_ff, goal_in;
   logic                     neg_ff, neg_in, turning_ff, turning_in;
   logic [15:0]              ms_ff, ms_in;

   // latched request word
   logic [9:0]         el_ff, el_in;
   logic               gv_ff, gv_in;
   logic signed [15:0] rate_ff, rate_in;

   logic signed [ACC_W-1:0]  deriv_ff, deriv_in, quo_ff, quo_in;
   logic signed [PROD_W-1:0] sum_ff, sum_in;
   logic                     qneg_ff, qneg_in;

   logic signed [1:0] dira_ff, dira_in, dirb_ff, dirb_in;
   logic [7:0]        speed_ff, speed_in;
   logic              done_ff, done_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [1:0]        rsp_dira_ff, rsp_dira_in, rsp_dirb_ff, rsp_dirb_in;
   logic [7:0]               rsp_speed_ff, rsp_speed_in;
   logic                     rsp_act_ff, rsp_act_in, rsp_done_ff, rsp_done_in;
   logic signed [HEAD_W-1:0] rsp_head_ff, rsp_head_in;

   // shared arithmetic units
   unit_ctl_type             mul_ctl, div_ctl;
   logic                     mul_go_ff, mul_go_in, div_go_ff, div_go_in;
   logic signed [ACC_W-1:0]  mul_a_ff, mul_a_in;
   logic [MULB_W-1:0]        mul_b_ff, mul_b_in;
   logic [ACC_W-1:0]         div_n_ff, div_n_in;
   logic [DIVD_W-1:0]        div_d_ff, div_d_in;
   logic                     mul_done, div_done;
   logic signed [PROD_W-1:0] product;
   logic [ACC_W-1:0]         quotient;

   assign mul_ctl = '{go: mul_go_ff, done: 1'b0};
   assign div_ctl = '{go: div_go_ff, done: 1'b0};

   ghpt_smul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (mul_ctl),
      .op_a    (mul_a_ff),
      .op_b    (mul_b_ff),
      .done    (mul_done),
      .product (product)
   );

   ghpt_sdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl_i    (div_ctl),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // handshakes
   logic req_take, rsp_free;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // start: goal = heading*sign + |target|
   logic               tneg;
   logic signed [13:0] t14, tabs;
   logic signed [24:0] h25, hstart, hsgn;
   logic signed [GOAL_W-1:0] goal_start;
   assign tneg       = req_ch.turn_target[12];
   assign t14        = {req_ch.turn_target[12], req_ch.turn_target};
   assign tabs       = tneg ? -t14 : t14;
   assign h25        = {heading_ff[HEAD_W-1], heading_ff};
   assign hstart     = tneg ? -h25 : h25;
   assign goal_start = {hstart[24], hstart} + {12'b0, tabs};

   // error = goal - heading*sign, clamped
   logic signed [26:0] err27;
   assign hsgn  = neg_ff ? -h25 : h25;
   assign err27 = {goal_ff[GOAL_W-1], goal_ff} - {{2{hsgn[24]}}, hsgn};

   // integral update
   logic signed [ACC_W:0] integ_sum;
   assign integ_sum = {integ_ff[ACC_W-1], integ_ff} + product[ACC_W:0];

   // (error - previous) * 1000 as 1024 - 16 - 8
   logic signed [24:0] diff25;
   logic signed [35:0] dx, d1000, dabs;
   assign diff25 = {err_ff[HEAD_W-1], err_ff} - {prev_ff[HEAD_W-1], prev_ff};
   assign dx     = {{11{diff25[24]}}, diff25};
   assign d1000  = (dx <<< 10) - (dx <<< 4) - (dx <<< 3);
   assign dabs   = d1000[35] ? -d1000 : d1000;

   logic [ACC_W-1:0] integ_abs;
   assign integ_abs = integ_ff[ACC_W-1] ? ACC_W'(-integ_ff) : integ_ff;

   logic signed [ACC_W-1:0] quo_signed;
   assign quo_signed = qneg_ff ? -$signed(quotient) : $signed(quotient);

   // final PID sum and drive
   logic signed [PROD_W-1:0] sum_fin, sum_abs;
   logic [55:0]              mag56;
   logic [7:0]               mag8, spd8;
   logic                     dir_pos;
   logic [24:0]              err_abs;
   logic                     reached;
   assign sum_fin = sum_ff + product;
   assign sum_abs = sum_fin[PROD_W-1] ? -sum_fin : sum_fin;
   assign mag56   = sum_abs[PROD_W-1:8];
   assign mag8    = (mag56 > {48'b0, limit_ff}) ? limit_ff : mag56[7:0];
   assign spd8    = (mag8 > minspd_ff) ? mag8 : minspd_ff;
   assign dir_pos = ((sum_fin > 0) != neg_ff);
   assign err_abs = err_ff[HEAD_W-1] ? 25'(-{err_ff[HEAD_W-1], err_ff})
                                     : 25'({err_ff[HEAD_W-1], err_ff});
   assign reached = err_abs < {13'b0, band_ff};

   // gyro step
   logic [16:0] ms17, rate_abs;
   logic [15:0] ms_new;
   logic        gy_pass, gy_big;
   assign ms17     = {1'b0, ms_ff} + {7'b0, el_ff};
   assign ms_new   = ms17[16] ? 16'hFFFF : ms17[15:0];
   assign gy_pass  = gv_ff && (ms_new >= {6'b0, period_ff});
   assign rate_abs = rate_ff[15] ? 17'(-{rate_ff[15], rate_ff}) : 17'({rate_ff[15], rate_ff});
   assign gy_big   = rate_abs > {5'b0, deadband_ff};

   logic signed [ACC_W:0]   acc_sum;
   logic signed [ACC_W-1:0] acc_new;
   logic [ACC_W-1:0]        acc_abs;
   assign acc_sum = {acc_ff[ACC_W-1], acc_ff} + product[ACC_W:0];
   assign acc_new = sat48(acc_sum);
   assign acc_abs = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : acc_new;

   // heading = acc / 1000, clamped
   logic signed [ACC_W-1:0] qneg_val;
   logic signed [HEAD_W-1:0] head_sat;
   assign qneg_val = -$signed(quotient);
   always_comb begin
      if (qneg_ff) begin
         if (quotient > {{(ACC_W-HEAD_W){1'b0}}, 1'b1, {(HEAD_W-1){1'b0}}}) head_sat = H_MIN;
         else head_sat = qneg_val[HEAD_W-1:0];
      end else begin
         if (quotient > {{(ACC_W-HEAD_W+1){1'b0}}, {(HEAD_W-1){1'b1}}}) head_sat = H_MAX;
         else head_sat = quotient[HEAD_W-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      integ_in   = integ_ff;
      heading_in = heading_ff;
      prev_in    = prev_ff;
      err_in     = err_ff;
      goal_in    = goal_ff;
      neg_in     = neg_ff;
      turning_in = turning_ff;
      ms_in      = ms_ff;
      el_in      = el_ff;
      gv_in      = gv_ff;
      rate_in    = rate_ff;
      deriv_in   = deriv_ff;
      quo_in     = quo_ff;
      sum_in     = sum_ff;
      qneg_in    = qneg_ff;
      dira_in    = dira_ff;
      dirb_in    = dirb_ff;
      speed_in   = speed_ff;
      done_in    = done_ff;
      mul_go_in  = 1'b0;
      div_go_in  = 1'b0;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      div_n_in   = div_n_ff;
      div_d_in   = div_d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_dira_in  = rsp_dira_ff;
      rsp_dirb_in  = rsp_dirb_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_head_in  = rsp_head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               el_in    = req_ch.elapsed_ms;
               gv_in    = req_ch.gyro_valid;
               rate_in  = req_ch.gyro_rate;
               dira_in  = DIR_STOP;
               dirb_in  = DIR_STOP;
               speed_in = '0;
               done_in  = 1'b0;
               if (req_ch.req_type == REQ_START) begin
                  // latch the turn, clear the controller history
                  goal_in    = goal_start;
                  neg_in     = tneg;
                  integ_in   = '0;
                  prev_in    = '0;
                  turning_in = 1'b1;
                  state_in   = S_OUT;
               end else if (turning_ff) begin
                  state_in = S_ERR;
               end else begin
                  state_in = S_GYRO;
               end
            end
         end
         S_ERR: begin
            err_in    = sat24(err27);
            mul_a_in  = ACC_W'(sat24(err27));
            mul_b_in  = {6'b0, el_ff};
            mul_go_in = 1'b1;
            state_in  = S_MINT;
         end
         S_MINT: begin
            if (mul_done) begin
               integ_in  = sat48(integ_sum);
               div_n_in  = {12'b0, dabs};
               div_d_in  = el_ff;
               qneg_in   = d1000[35];
               div_go_in = 1'b1;
               state_in  = S_DDIV;
            end
         end
         S_DDIV: begin
            if (div_done) begin
               // no derivative when no time has passed
               deriv_in  = (el_ff == '0) ? '0 : quo_signed;
               div_n_in  = integ_abs;
               div_d_in  = MILLI;
               qneg_in   = integ_ff[ACC_W-1];
               div_go_in = 1'b1;
               state_in  = S_IDIV;
            end
         end
         S_IDIV: begin
            if (div_done) begin
               quo_in    = quo_signed;
               mul_a_in  = ACC_W'(err_ff);
               mul_b_in  = kp_ff;
               mul_go_in = 1'b1;
               state_in  = S_MKP;
            end
         end
         S_MKP: begin
            if (mul_done) begin
               sum_in    = product;
               mul_a_in  = quo_ff;
               mul_b_in  = ki_ff;
               mul_go_in = 1'b1;
               state_in  = S_MKI;
            end
         end
         S_MKI: begin
            if (mul_done) begin
               sum_in    = sum_ff + product;
               mul_a_in  = deriv_ff;
               mul_b_in  = kd_ff;
               mul_go_in = 1'b1;
               state_in  = S_MKD;
            end
         end
         S_MKD: begin
            if (mul_done) begin
               prev_in = err_ff;
               if (reached) begin
                  // target reached: stop both motors and end the turn
                  dira_in    = DIR_STOP;
                  dirb_in    = DIR_STOP;
                  speed_in   = '0;
                  done_in    = 1'b1;
                  turning_in = 1'b0;
               end else begin
                  dira_in  = dir_pos ? DIR_REV : DIR_FWD;
                  dirb_in  = dir_pos ? DIR_FWD : DIR_REV;
                  speed_in = spd8;
               end
               state_in = S_GYRO;
            end
         end
         S_GYRO: begin
            ms_in    = ms_new;
            state_in = S_OUT;
            if (gy_pass) begin
               ms_in = '0;
               if (gy_big) begin
                  mul_a_in  = ACC_W'(rate_ff);
                  mul_b_in  = ms_new;
                  mul_go_in = 1'b1;
                  state_in  = S_MGY;
               end
            end
         end
         S_MGY: begin
            if (mul_done) begin
               acc_in    = acc_new;
               div_n_in  = acc_abs;
               div_d_in  = MILLI;
               qneg_in   = acc_new[ACC_W-1];
               div_go_in = 1'b1;
               state_in  = S_HDIV;
            end
         end
         S_HDIV: begin
            if (div_done) begin
               heading_in = head_sat;
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the response register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_dira_in  = dira_ff;
               rsp_dirb_in  = dirb_ff;
               rsp_speed_in = speed_ff;
               rsp_act_in   = turning_ff;
               rsp_done_in  = done_ff;
               rsp_head_in  = heading_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      el_ff    <= el_in;
      gv_ff    <= gv_in;
      rate_ff  <= rate_in;
      err_ff   <= err_in;
      deriv_ff <= deriv_in;
      quo_ff   <= quo_in;
      sum_ff   <= sum_in;
      qneg_ff  <= qneg_in;
      dira_ff  <= dira_in;
      dirb_ff  <= dirb_in;
      speed_ff <= speed_in;
      done_ff  <= done_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      div_n_ff <= div_n_in;
      div_d_ff <= div_d_in;
      rsp_dira_ff  <= rsp_dira_in;
      rsp_dirb_ff  <= rsp_dirb_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_head_ff  <= rsp_head_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         integ_ff     <= '0;
         heading_ff   <= '0;
         prev_ff      <= '0;
         goal_ff      <= '0;
         neg_ff       <= 1'b0;
         turning_ff   <= 1'b0;
         ms_ff        <= '0;
         mul_go_ff    <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         integ_ff     <= integ_in;
         heading_ff   <= heading_in;
         prev_ff      <= prev_in;
         goal_ff      <= goal_in;
         neg_ff       <= neg_in;
         turning_ff   <= turning_in;
         ms_ff        <= ms_in;
         mul_go_ff    <= mul_go_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff       <= 16'd256;
         ki_ff       <= 16'd0;
         kd_ff       <= 16'd0;
         period_ff   <= 10'd10;
         deadband_ff <= 12'd16;
         minspd_ff   <= 8'd30;
         limit_ff    <= 8'd100;
         band_ff     <= 12'd48;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_idx_type'(csr_ch.addr))
            CSR_KP:       kp_ff       <= csr_ch.data;
            CSR_KI:       ki_ff       <= csr_ch.data;
            CSR_KD:       kd_ff       <= csr_ch.data;
            CSR_PERIOD:   period_ff   <= csr_ch.data[9:0];
            CSR_DEADBAND: deadband_ff <= csr_ch.data[11:0];
            CSR_MINSPD:   minspd_ff   <= csr_ch.data[7:0];
            CSR_LIMIT:    limit_ff    <= csr_ch.data[7:0];
            CSR_BAND:     band_ff     <= csr_ch.data[11:0];
            default:      ;
         endcase
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.dir_a       = rsp_dira_ff;
   assign rsp_ch.dir_b       = rsp_dirb_ff;
   assign rsp_ch.drive_speed = rsp_speed_ff;
   assign rsp_ch.turn_active = rsp_act_ff;
   assign rsp_ch.turn_done   = rsp_done_ff;
   assign rsp_ch.heading     = rsp_head_ff;
endmodule
